[src/mctr_pkg.sv]
// shared types and constants for the multicore timer register block
// no dependencies
`default_nettype none
package mctr_pkg;
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [11:0] A_CNT_LO  = 12'h100;
    localparam logic [11:0] A_CNT_HI  = 12'h104;
    localparam logic [11:0] A_CNT_WS  = 12'h110;
    localparam logic [11:0] A_CMP_LO  = 12'h200;
    localparam logic [11:0] A_CMP_HI  = 12'h204;
    localparam logic [11:0] A_CMP_INC = 12'h208;
    localparam logic [11:0] A_G_CTRL  = 12'h240;
    localparam logic [11:0] A_G_STAT  = 12'h244;
    localparam logic [11:0] A_G_IEN   = 12'h248;
    localparam logic [11:0] A_G_WS    = 12'h24C;
    localparam logic [11:0] A_LOCAL   = 12'h300;

    localparam logic [7:0] L_TBUF  = 8'h00;
    localparam logic [7:0] L_TCNT  = 8'h04;
    localparam logic [7:0] L_IBUF  = 8'h08;
    localparam logic [7:0] L_ICNT  = 8'h0C;
    localparam logic [7:0] L_CTRL  = 8'h20;
    localparam logic [7:0] L_STAT  = 8'h30;
    localparam logic [7:0] L_IEN   = 8'h34;
    localparam logic [7:0] L_WS    = 8'h40;

    // one bus word as registered at the input
    typedef struct packed {
        logic        valid;
        logic [1:0]  command;
        logic [11:0] address;
        logic [31:0] write_data;
    } bus_word_t;
endpackage
`default_nettype wire

[src/multicore_timer_registers.sv]
// top level of the multicore timer register block
// depends on mctr_pkg, mctr_global and mctr_local
`default_nettype none
// Timer block driven by bus words (tick, read, write). A word is registered
// at the input; once the output register can take a result, the timer state
// updates and the result is loaded into the output register, where it is held
// until taken. One word is accepted every cycle while the output register is
// free or being taken; a stalled result holds the input. The irq outputs
// follow the timer flags, which only move when a result is loaded, so they
// belong to the result on show.
module multicore_timer_registers
    import mctr_pkg::*;
#(
    parameter int NUM_LOCAL = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [11:0] address,
    input  wire logic [31:0] write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      read_data,
    output logic             global_irq,
    output logic [3:0]       local_irq_lines
);
    localparam int NL = (NUM_LOCAL < 1) ? 1 : NUM_LOCAL;
    localparam int NIRQ = (NL < 4) ? NL : 4;

    bus_word_t     word_reg, word_next, word_go;
    logic          out_valid_reg;
    logic [31:0]   rd_reg;
    logic [3:0]    lirq;
    logic [31:0]   g_rdata, l_rdata;
    logic [31:0]   loc_rdata [NL];
    logic [NL-1:0] loc_irq;
    logic          g_irq;
    logic          stage_free;
    logic [11:0]   loc_off;

    // input stage moves on whenever the output register can take a result
    assign stage_free = !out_valid_reg || out_ready;
    assign in_ready   = stage_free;
    assign loc_off    = word_reg.address - A_LOCAL;

    always_comb
    begin
        word_next = word_reg;
        if (stage_free)
        begin
            word_next.valid      = in_valid;
            word_next.command    = command;
            word_next.address    = address;
            word_next.write_data = write_data;
        end
    end

    // state updates only when the word moves into the output register
    always_comb
    begin
        word_go = word_reg;
        word_go.valid = word_reg.valid && stage_free;
    end

    mctr_global u_global (
        .clk(clk), .rst_n(rst_n), .word(word_go), .rdata(g_rdata), .irq(g_irq)
    );

    for (genvar t = 0; t < NL; t++)
    begin : g_loc
        logic sel;
        assign sel = (word_reg.address >= A_LOCAL) &&
                     ({4'd0, loc_off[11:8]} == 8'(t));
        mctr_local u_local (
            .clk(clk), .rst_n(rst_n), .word(word_go), .sel(sel),
            .rdata(loc_rdata[t]), .irq(loc_irq[t])
        );
    end

    always_comb
    begin
        l_rdata = '0;
        for (int t = 0; t < NL; t++) l_rdata = l_rdata | loc_rdata[t];
        lirq = '0;
        for (int t = 0; t < NIRQ; t++) lirq[t] = loc_irq[t];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_reg        <= '0;
        end
        else
        begin
            word_reg <= word_next;
            if (stage_free)
            begin
                out_valid_reg <= word_reg.valid;
                if (word_reg.valid) rd_reg <= g_rdata | l_rdata;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = rd_reg;
    assign global_irq      = g_irq;
    assign local_irq_lines = lirq;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data))
        else $error("result changed while stalled");
    a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");
    a_irqhold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(local_irq_lines) && $stable(global_irq))
        else $error("irq changed while stalled");
`endif
endmodule
`default_nettype wire

[src/mctr_local.sv]
// one local tick timer with its divider, interrupt counter and flags
// depends on mctr_pkg
`default_nettype none
module mctr_local
    import mctr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire bus_word_t word,
    input  wire logic      sel,
    output logic [31:0]    rdata,
    output logic           irq
);
    logic [31:0] tbuf_reg, tbuf_next, tcnt_reg, tcnt_next;
    logic [30:0] ibuf_reg, ibuf_next, icnt_reg, icnt_next;
    logic [2:0]  ctrl_reg, ctrl_next;
    logic [4:0]  flags_reg, flags_next;
    logic [7:0]  off;
    logic        fire;

    assign off = word.address[7:0];
    assign irq = flags_reg[0] & flags_reg[1];

    always_comb
    begin
        tbuf_next = tbuf_reg; tcnt_next = tcnt_reg;
        ibuf_next = ibuf_reg; icnt_next = icnt_reg;
        ctrl_next = ctrl_reg; flags_next = flags_reg;
        fire = 1'b0;
        rdata = '0;
        if (word.valid && word.command == CMD_TICK)
        begin
            if (ctrl_reg[0])
            begin
                if (tcnt_reg == '0)
                begin
                    tcnt_next = tbuf_reg;
                    fire = 1'b1;
                end
                else
                begin
                    tcnt_next = tcnt_reg - 32'd1;
                end
            end
            if (fire && ctrl_reg[1])
            begin
                if (icnt_reg <= 31'd1)
                begin
                    flags_next[0] = 1'b1;
                    if (ctrl_reg[2])
                    begin
                        icnt_next = ibuf_reg;
                    end
                    else
                    begin
                        icnt_next = '0;
                        ctrl_next[1] = 1'b0;
                    end
                end
                else
                begin
                    icnt_next = icnt_reg - 31'd1;
                end
            end
        end
        else if (word.valid && sel && word.command == CMD_READ)
        begin
            case (off)
                L_TBUF: rdata = tbuf_reg;
                L_TCNT: rdata = tcnt_reg;
                L_IBUF: rdata = {1'b0, ibuf_reg};
                L_ICNT: rdata = {1'b0, icnt_reg};
                L_CTRL: rdata = {29'd0, ctrl_reg};
                L_STAT: rdata = {31'd0, flags_reg[0]};
                L_IEN:  rdata = {31'd0, flags_reg[1]};
                L_WS:   rdata = {28'd0, flags_reg[4], 1'b0, flags_reg[3:2]};
                default: rdata = '0;
            endcase
        end
        else if (word.valid && sel && word.command == CMD_WRITE)
        begin
            case (off)
                L_TBUF:
                begin
                    tbuf_next = word.write_data;
                    flags_next[2] = 1'b1;
                end
                L_IBUF:
                begin
                    ibuf_next = word.write_data[30:0];
                    if (word.write_data[31]) icnt_next = word.write_data[30:0];
                    flags_next[3] = 1'b1;
                end
                L_CTRL:
                begin
                    ctrl_next = word.write_data[2:0];
                    flags_next[4] = 1'b1;
                end
                L_STAT: if (word.write_data[0]) flags_next[0] = 1'b0;
                L_IEN:  flags_next[1] = word.write_data[0];
                L_WS:
                begin
                    if (word.write_data[0]) flags_next[2] = 1'b0;
                    if (word.write_data[1]) flags_next[3] = 1'b0;
                    if (word.write_data[3]) flags_next[4] = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbuf_reg <= '0; tcnt_reg <= '0; ibuf_reg <= '0; icnt_reg <= '0;
            ctrl_reg <= '0; flags_reg <= '0;
        end
        else
        begin
            tbuf_reg <= tbuf_next; tcnt_reg <= tcnt_next;
            ibuf_reg <= ibuf_next; icnt_reg <= icnt_next;
            ctrl_reg <= ctrl_next; flags_reg <= flags_next;
        end
    end
endmodule
`default_nettype wire

[src/mctr_global.sv]
// global 64-bit counter, comparator and their control and status registers
// depends on mctr_pkg
`default_nettype none
module mctr_global
    import mctr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire bus_word_t word,
    output logic [31:0]    rdata,
    output logic           irq
);
    logic [63:0] cnt_reg, cnt_next, cmp_reg, cmp_next, cnt_inc;
    logic [31:0] inc_reg, inc_next;
    logic [2:0]  ctrl_reg, ctrl_next;
    logic [1:0]  flags_reg, flags_next;
    logic [5:0]  ws_reg, ws_next;
    logic [31:0] d;

    assign d = word.write_data;
    assign cnt_inc = cnt_reg + 64'd1;
    assign irq = flags_reg[0] & flags_reg[1];

    always_comb
    begin
        cnt_next = cnt_reg; cmp_next = cmp_reg; inc_next = inc_reg;
        ctrl_next = ctrl_reg; flags_next = flags_reg; ws_next = ws_reg;
        rdata = '0;
        if (word.valid && word.command == CMD_TICK)
        begin
            if (ctrl_reg[2])
            begin
                cnt_next = cnt_inc;
                if (ctrl_reg[0] && cnt_inc == cmp_reg)
                begin
                    flags_next[0] = 1'b1;
                    if (ctrl_reg[1]) cmp_next = cmp_reg + {32'd0, inc_reg};
                end
            end
        end
        else if (word.valid && word.command == CMD_READ)
        begin
            case (word.address)
                A_CNT_LO:  rdata = cnt_reg[31:0];
                A_CNT_HI:  rdata = cnt_reg[63:32];
                A_CNT_WS:  rdata = {30'd0, ws_reg[1:0]};
                A_CMP_LO:  rdata = cmp_reg[31:0];
                A_CMP_HI:  rdata = cmp_reg[63:32];
                A_CMP_INC: rdata = inc_reg;
                A_G_CTRL:  rdata = {23'd0, ctrl_reg[2], 6'd0, ctrl_reg[1:0]};
                A_G_STAT:  rdata = {31'd0, flags_reg[0]};
                A_G_IEN:   rdata = {31'd0, flags_reg[1]};
                A_G_WS:    rdata = {15'd0, ws_reg[5], 13'd0, ws_reg[4:2]};
                default:   rdata = '0;
            endcase
        end
        else if (word.valid && word.command == CMD_WRITE)
        begin
            case (word.address)
                A_CNT_LO:
                begin
                    cnt_next[31:0] = d; ws_next[0] = 1'b1;
                end
                A_CNT_HI:
                begin
                    cnt_next[63:32] = d; ws_next[1] = 1'b1;
                end
                A_CNT_WS:  ws_next[1:0] = ws_reg[1:0] & ~d[1:0];
                A_CMP_LO:
                begin
                    cmp_next[31:0] = d; ws_next[2] = 1'b1;
                end
                A_CMP_HI:
                begin
                    cmp_next[63:32] = d; ws_next[3] = 1'b1;
                end
                A_CMP_INC:
                begin
                    inc_next = d; ws_next[4] = 1'b1;
                end
                A_G_CTRL:
                begin
                    ctrl_next = {d[8], d[1:0]}; ws_next[5] = 1'b1;
                end
                A_G_STAT:  if (d[0]) flags_next[0] = 1'b0;
                A_G_IEN:   flags_next[1] = d[0];
                A_G_WS:    ws_next[5:2] = ws_reg[5:2] & ~{d[16], d[2:0]};
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0; cmp_reg <= '0; inc_reg <= '0;
            ctrl_reg <= '0; flags_reg <= '0; ws_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next; cmp_reg <= cmp_next; inc_reg <= inc_next;
            ctrl_reg <= ctrl_next; flags_reg <= flags_next; ws_reg <= ws_next;
        end
    end
endmodule
`default_nettype wire
